// File: src/rdsp_pkg.sv
// rdsp_pkg: word types and codes for the radix digit scatter pass
// no dependencies; imported by the top level

package rdsp_pkg;

    localparam int KEY_W   = 32;
    localparam int POS_W   = 10;
    localparam int SHIFT_W = 5;

    // opcodes of an input word
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_READ = 1'b1;

    // status codes of a result word
    localparam logic ST_OK    = 1'b0;
    localparam logic ST_EMPTY = 1'b1;

    typedef struct packed {
        logic             opcode;
        logic [KEY_W-1:0] key;
        logic             last;
    } t_in_word;

    typedef struct packed {
        logic [KEY_W-1:0] sorted_key;
        logic [POS_W-1:0] position;
        logic             last_of_run;
        logic             status;
    } t_out_word;

endpackage

// File: src/rdsp_key_ram.sv
// rdsp_key_ram: one-write one-read synchronous key memory, registered read data
// no dependencies; used for the input and output key stores

module rdsp_key_ram #(
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = 10,
    parameter int DATA_W = 32
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [DATA_W-1:0] i_wr_data,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [DATA_W-1:0] o_rd_data
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_q;

    // write port and registered read port, read returns old data on collision
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_q <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_q;

endmodule

// File: src/rdsp_hist_ram.sv
// rdsp_hist_ram: histogram memory with per-bin valid bits, unwritten bins read zero
// no dependencies; used by the top level for counts and prefix offsets

module rdsp_hist_ram #(
    parameter int ADDR_W = 8,
    parameter int DATA_W = 11
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_clear,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [DATA_W-1:0] i_wr_data,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [DATA_W-1:0] o_rd_data
);

    localparam int DEPTH = 1 << ADDR_W;

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DEPTH-1:0]  r_vld;
    logic [DATA_W-1:0] r_q;
    logic              r_q_vld;

    // storage array and registered read
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_q <= r_mem[i_rd_addr];
        end
    end

    // valid bits, cleared at once on reset or a new set
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld   <= '0;
            r_q_vld <= 1'b0;
        end else begin
            if (i_clear) begin
                r_vld <= '0;
            end else if (i_wr_en) begin
                r_vld[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_q_vld <= r_vld[i_rd_addr] && !i_clear;
            end
        end
    end

    assign o_rd_data = r_q_vld ? r_q : '0;

endmodule

// File: src/radix_digit_scatter_pass_top.sv
// radix_digit_scatter_pass_top: one counting-sort pass of an lsd radix sort
// depends on rdsp_pkg, rdsp_key_ram, rdsp_hist_ram
//
// usage: input words arrive on i_in_valid / i_in_word / o_in_stall, results
// leave on o_out_valid / o_out_word / i_out_stall. a load word stores a key and
// bumps its digit bin, unless the store is full (read-modify-write of the
// histogram ram). a load flagged last starts the pass: a prefix sum over
// 2^DIGIT_BITS bins, then the scatter pipeline, one key per cycle through
// input ram, histogram ram and output ram. o_in_stall is high for all of that.
// a read word gives one result: an empty status result is registered at the
// accept edge, a key result in S_READ after the output ram read, once the
// output register is free; the next word waits out S_READ after a key read,
// not after an empty read. the result sits in an output register; while
// i_out_stall holds it, loads are still taken but read words stall. a load
// after a finished pass starts a new set and clears the histogram valid bits.
// reset clears all control state and the histogram valid bits; the key stores
// are not cleared. the user must write digit_shift on i_cfg_we only while the
// block is idle; this is not enforced.

module radix_digit_scatter_pass_top
    import rdsp_pkg::*;
#(
    parameter int MAX_KEYS   = 1024,
    parameter int DIGIT_BITS = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [SHIFT_W-1:0] i_cfg_data,
    input  logic               i_in_valid,
    input  t_in_word           i_in_word,
    output logic               o_in_stall,
    output logic               o_out_valid,
    output t_out_word          o_out_word,
    input  logic               i_out_stall
);

    localparam int CNT_W  = $clog2(MAX_KEYS + 1);
    localparam int ADDR_W = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
    localparam int NBINS  = 1 << DIGIT_BITS;
    localparam int BIN_W  = DIGIT_BITS + 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD_WB,
        S_PREFIX,
        S_SCATTER,
        S_READ
    } t_state;

    function automatic logic [DIGIT_BITS-1:0] f_digit(
        input logic [KEY_W-1:0]   k,
        input logic [SHIFT_W-1:0] s
    );
        logic [KEY_W-1:0] sh;
        sh = k >> s;
        return sh[DIGIT_BITS-1:0];
    endfunction

    t_state                r_state;
    logic [SHIFT_W-1:0]    r_shift;
    logic [CNT_W-1:0]      r_key_cnt;
    logic                  r_reading;
    logic [CNT_W-1:0]      r_rp;
    logic                  r_ld_wr;
    logic                  r_ld_last;
    logic [DIGIT_BITS-1:0] r_ld_dig;
    logic [BIN_W-1:0]      r_pf_bin;
    logic                  r_pf_vld;
    logic [DIGIT_BITS-1:0] r_pf_wbin;
    logic [CNT_W-1:0]      r_run;
    logic [CNT_W-1:0]      r_sc_idx;
    logic                  r_s2_vld;
    logic                  r_s3_vld;
    logic [KEY_W-1:0]      r_s3_key;
    logic [DIGIT_BITS-1:0] r_s3_dig;
    logic                  r_fw_vld;
    logic [DIGIT_BITS-1:0] r_fw_dig;
    logic [CNT_W-1:0]      r_fw_next;
    logic [CNT_W-1:0]      r_rd_pos;
    logic                  r_rd_last;
    logic                  r_out_vld;
    t_out_word             r_out_word;

    logic                  in_acc;
    logic                  ld_acc;
    logic                  rd_acc;
    logic [DIGIT_BITS-1:0] in_dig;
    logic [CNT_W-1:0]      eff_cnt;
    logic                  ld_full;
    logic                  rd_ok;
    logic                  out_free;
    logic                  out_set;
    logic                  pf_issue;
    logic                  pf_done;
    logic                  sc_issue;
    logic                  sc_done;
    logic [DIGIT_BITS-1:0] s2_dig;
    logic [CNT_W-1:0]      s3_slot;

    logic                  h_clear;
    logic                  h_wr_en;
    logic [DIGIT_BITS-1:0] h_wr_addr;
    logic [CNT_W-1:0]      h_wr_data;
    logic                  h_rd_en;
    logic [DIGIT_BITS-1:0] h_rd_addr;
    logic [CNT_W-1:0]      h_rd_data;

    logic                  ki_wr_en;
    logic                  ki_rd_en;
    logic [KEY_W-1:0]      ki_rd_data;
    logic                  ko_wr_en;
    logic                  ko_rd_en;
    logic [KEY_W-1:0]      ko_rd_data;

    // handshake decode
    assign out_free   = !r_out_vld || !i_out_stall;
    assign o_in_stall = (r_state != S_IDLE) || ((i_in_word.opcode == OP_READ) && !out_free);
    assign in_acc     = i_in_valid && !o_in_stall;
    assign ld_acc     = in_acc && (i_in_word.opcode == OP_LOAD);
    assign rd_acc     = in_acc && (i_in_word.opcode == OP_READ);

    // load and read side conditions
    assign in_dig  = f_digit(i_in_word.key, r_shift);
    assign eff_cnt = r_reading ? '0 : r_key_cnt;
    assign ld_full = (eff_cnt == CNT_W'(MAX_KEYS));
    assign rd_ok   = r_reading && (r_rp < r_key_cnt);

    // output register load: empty result at the accept, key result after the ram read
    assign out_set = ((r_state == S_IDLE) && rd_acc && !rd_ok)
                   || ((r_state == S_READ) && out_free);

    // prefix sweep and scatter pipeline control
    assign pf_issue = (r_state == S_PREFIX) && (r_pf_bin < BIN_W'(NBINS));
    assign pf_done  = (r_state == S_PREFIX) && !pf_issue && !r_pf_vld;
    assign sc_issue = (r_state == S_SCATTER) && (r_sc_idx < r_key_cnt);
    assign sc_done  = (r_state == S_SCATTER) && !sc_issue && !r_s2_vld && !r_s3_vld;
    assign s2_dig   = f_digit(ki_rd_data, r_shift);

    // forward the previous write when the same bin is hit back to back
    assign s3_slot = (r_fw_vld && (r_fw_dig == r_s3_dig)) ? r_fw_next : h_rd_data;

    // histogram ram port steering
    always_comb begin
        h_clear   = ld_acc && r_reading;
        h_rd_en   = 1'b0;
        h_rd_addr = '0;
        h_wr_en   = 1'b0;
        h_wr_addr = '0;
        h_wr_data = '0;
        if (ld_acc && !ld_full) begin
            h_rd_en   = 1'b1;
            h_rd_addr = in_dig;
        end else if (pf_issue) begin
            h_rd_en   = 1'b1;
            h_rd_addr = r_pf_bin[DIGIT_BITS-1:0];
        end else if ((r_state == S_SCATTER) && r_s2_vld) begin
            h_rd_en   = 1'b1;
            h_rd_addr = s2_dig;
        end
        if ((r_state == S_LOAD_WB) && r_ld_wr) begin
            h_wr_en   = 1'b1;
            h_wr_addr = r_ld_dig;
            h_wr_data = h_rd_data + CNT_W'(1);
        end else if ((r_state == S_PREFIX) && r_pf_vld) begin
            h_wr_en   = 1'b1;
            h_wr_addr = r_pf_wbin;
            h_wr_data = r_run;
        end else if ((r_state == S_SCATTER) && r_s3_vld) begin
            h_wr_en   = 1'b1;
            h_wr_addr = r_s3_dig;
            h_wr_data = s3_slot + CNT_W'(1);
        end
    end

    // key store port enables
    assign ki_wr_en = ld_acc && !ld_full;
    assign ki_rd_en = sc_issue;
    assign ko_wr_en = (r_state == S_SCATTER) && r_s3_vld && (s3_slot < CNT_W'(MAX_KEYS));
    assign ko_rd_en = rd_acc && rd_ok;

    rdsp_hist_ram #(
        .ADDR_W (DIGIT_BITS),
        .DATA_W (CNT_W)
    ) u_hist (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_clear   (h_clear),
        .i_wr_en   (h_wr_en),
        .i_wr_addr (h_wr_addr),
        .i_wr_data (h_wr_data),
        .i_rd_en   (h_rd_en),
        .i_rd_addr (h_rd_addr),
        .o_rd_data (h_rd_data)
    );

    rdsp_key_ram #(
        .DEPTH  (MAX_KEYS),
        .ADDR_W (ADDR_W),
        .DATA_W (KEY_W)
    ) u_in_store (
        .i_clk     (i_clk),
        .i_wr_en   (ki_wr_en),
        .i_wr_addr (eff_cnt[ADDR_W-1:0]),
        .i_wr_data (i_in_word.key),
        .i_rd_en   (ki_rd_en),
        .i_rd_addr (r_sc_idx[ADDR_W-1:0]),
        .o_rd_data (ki_rd_data)
    );

    rdsp_key_ram #(
        .DEPTH  (MAX_KEYS),
        .ADDR_W (ADDR_W),
        .DATA_W (KEY_W)
    ) u_out_store (
        .i_clk     (i_clk),
        .i_wr_en   (ko_wr_en),
        .i_wr_addr (s3_slot[ADDR_W-1:0]),
        .i_wr_data (r_s3_key),
        .i_rd_en   (ko_rd_en),
        .i_rd_addr (r_rp[ADDR_W-1:0]),
        .o_rd_data (ko_rd_data)
    );

    // sequencer, counters and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_shift   <= '0;
            r_key_cnt <= '0;
            r_reading <= 1'b0;
            r_rp      <= '0;
            r_ld_wr   <= 1'b0;
            r_ld_last <= 1'b0;
            r_pf_bin  <= '0;
            r_pf_vld  <= 1'b0;
            r_run     <= '0;
            r_sc_idx  <= '0;
            r_s2_vld  <= 1'b0;
            r_s3_vld  <= 1'b0;
            r_fw_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_shift <= i_cfg_data;
            end
            if (out_set) begin
                r_out_vld <= 1'b1;
            end else if (r_out_vld && !i_out_stall) begin
                r_out_vld <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (ld_acc) begin
                        if (r_reading) begin
                            r_reading <= 1'b0;
                            r_rp      <= '0;
                        end
                        r_ld_wr   <= !ld_full;
                        r_ld_dig  <= in_dig;
                        r_ld_last <= i_in_word.last;
                        r_key_cnt <= ld_full ? eff_cnt : eff_cnt + CNT_W'(1);
                        r_state   <= S_LOAD_WB;
                    end else if (rd_acc) begin
                        if (rd_ok) begin
                            r_rd_pos  <= r_rp;
                            r_rd_last <= ((r_rp + CNT_W'(1)) == r_key_cnt);
                            r_rp      <= r_rp + CNT_W'(1);
                            r_state   <= S_READ;
                        end else begin
                            r_out_word <= '{sorted_key: '0, position: '0,
                                            last_of_run: 1'b0, status: ST_EMPTY};
                        end
                    end
                end
                S_LOAD_WB: begin
                    if (r_ld_last) begin
                        r_pf_bin <= '0;
                        r_pf_vld <= 1'b0;
                        r_run    <= '0;
                        r_state  <= S_PREFIX;
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                S_PREFIX: begin
                    r_pf_vld <= pf_issue;
                    if (pf_issue) begin
                        r_pf_wbin <= r_pf_bin[DIGIT_BITS-1:0];
                        r_pf_bin  <= r_pf_bin + BIN_W'(1);
                    end
                    if (r_pf_vld) begin
                        r_run <= r_run + h_rd_data;
                    end
                    if (pf_done) begin
                        r_sc_idx <= '0;
                        r_s2_vld <= 1'b0;
                        r_s3_vld <= 1'b0;
                        r_fw_vld <= 1'b0;
                        r_state  <= S_SCATTER;
                    end
                end
                S_SCATTER: begin
                    r_s2_vld <= sc_issue;
                    if (sc_issue) begin
                        r_sc_idx <= r_sc_idx + CNT_W'(1);
                    end
                    r_s3_vld <= r_s2_vld;
                    if (r_s2_vld) begin
                        r_s3_key <= ki_rd_data;
                        r_s3_dig <= s2_dig;
                    end
                    r_fw_vld <= r_s3_vld;
                    if (r_s3_vld) begin
                        r_fw_dig  <= r_s3_dig;
                        r_fw_next <= s3_slot + CNT_W'(1);
                    end
                    if (sc_done) begin
                        r_reading <= 1'b1;
                        r_rp      <= '0;
                        r_state   <= S_IDLE;
                    end
                end
                S_READ: begin
                    if (out_free) begin
                        r_out_word <= '{sorted_key: ko_rd_data,
                                        position: POS_W'(r_rd_pos),
                                        last_of_run: r_rd_last, status: ST_OK};
                        r_state    <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_word  = r_out_word;

    // prefix sweep must account for every stored key
    a_prefix_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pf_done |-> (r_run == r_key_cnt))
        else $error("prefix total differs from key count");

    // every scatter slot lands inside the loaded set
    a_slot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_SCATTER) && r_s3_vld) |-> (s3_slot < r_key_cnt))
        else $error("scatter slot out of range");

    // an accepted load always goes through the histogram write back
    a_load_wb: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ld_acc |=> (r_state == S_LOAD_WB))
        else $error("load skipped histogram write back");

    // end of the scatter opens the read side from position zero
    a_pass_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        sc_done |=> (r_reading && (r_rp == '0) && (r_state == S_IDLE)))
        else $error("pass did not hand over to reading");

    // key count never passes the store depth
    a_cnt_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_key_cnt <= CNT_W'(MAX_KEYS))
        else $error("key count beyond capacity");

endmodule

// File: bench/tb_radix_digit_scatter_pass_top.sv
// tb_radix_digit_scatter_pass_top: self-checking bench for the radix digit scatter pass
// depends on rdsp_pkg and radix_digit_scatter_pass_top; keeps its own sort model
`timescale 1ns / 1ps

module tb_radix_digit_scatter_pass_top;
    import rdsp_pkg::*;

    localparam int MAX_KEYS    = 1024;
    localparam int DIGIT_BITS  = 8;
    localparam int NUM_BINS    = 1 << DIGIT_BITS;
    localparam int MAX_GAP     = 17;
    // prefix sum plus a full scatter plus margin
    localparam int SETTLE      = NUM_BINS + 2 + MAX_KEYS + 3 + 40;
    localparam int CYCLE_LIMIT = 600000;
    localparam int RANDOM_WORDS = 950;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_we = 1'b0;
    logic [SHIFT_W-1:0] i_cfg_data = '0;
    logic               i_in_valid = 1'b0;
    t_in_word           i_in_word = '0;
    logic               o_in_stall;
    logic               o_out_valid;
    t_out_word          o_out_word;
    logic               i_out_stall = 1'b0;

    radix_digit_scatter_pass_top #(
        .MAX_KEYS  (MAX_KEYS),
        .DIGIT_BITS(DIGIT_BITS)
    ) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_in_valid (i_in_valid),
        .i_in_word  (i_in_word),
        .o_in_stall (o_in_stall),
        .o_out_valid(o_out_valid),
        .o_out_word (o_out_word),
        .i_out_stall(i_out_stall)
    );

    always #1 i_clk = ~i_clk;

    // sort model state
    logic [KEY_W-1:0]   loaded_keys [MAX_KEYS];
    logic [KEY_W-1:0]   sorted_keys [MAX_KEYS];
    int unsigned        bin_count [NUM_BINS];
    int unsigned        key_total;
    int unsigned        read_idx;
    bit                 sorted_ready;
    logic [SHIFT_W-1:0] shift_val;

    t_out_word expected_words[$];

    int  error_count;
    int  words_sent;
    int  results_checked;
    int  passes_run;
    int  cycle_count;
    int  stall_left;
    bit  no_idle;

    // one line per mismatch
    task automatic report(input string msg);
        $display("mismatch at cycle %0d: %s", cycle_count, msg);
        error_count++;
    endtask

    function automatic int draw_gap();
        if (no_idle || $urandom_range(0, 2) == 0)
            return 0;
        return $urandom_range(0, MAX_GAP);
    endfunction

    function automatic logic [DIGIT_BITS-1:0] key_digit(logic [KEY_W-1:0] k);
        logic [KEY_W-1:0] shifted;
        shifted = k >> shift_val;
        return shifted[DIGIT_BITS-1:0];
    endfunction

    // exclusive prefix sums, then stable scatter in arrival order
    function automatic void scatter_keys();
        int unsigned running;
        int unsigned cnt;
        int unsigned slot;
        logic [DIGIT_BITS-1:0] d;
        running = 0;
        for (int b = 0; b < NUM_BINS; b++) begin
            cnt = bin_count[b];
            bin_count[b] = running;
            running += cnt;
        end
        for (int i = 0; i < key_total; i++) begin
            d = key_digit(loaded_keys[i]);
            slot = bin_count[d];
            if (slot < MAX_KEYS)
                sorted_keys[slot] = loaded_keys[i];
            bin_count[d] = slot + 1;
        end
        read_idx = 0;
        sorted_ready = 1'b1;
        passes_run++;
    endfunction

    // update the model for one accepted word, queue the result of a read
    function automatic void predict_word(t_in_word w);
        t_out_word res;
        if (w.opcode == OP_LOAD) begin
            if (sorted_ready) begin
                foreach (bin_count[b]) bin_count[b] = 0;
                key_total = 0;
                read_idx = 0;
                sorted_ready = 1'b0;
            end
            if (key_total < MAX_KEYS) begin
                loaded_keys[key_total] = w.key;
                bin_count[key_digit(w.key)]++;
                key_total++;
            end
            if (w.last)
                scatter_keys();
        end else begin
            res = '0;
            if (sorted_ready && read_idx < key_total) begin
                res.sorted_key  = sorted_keys[read_idx];
                res.position    = read_idx[POS_W-1:0];
                res.last_of_run = (read_idx + 1 == key_total);
                res.status      = ST_OK;
                read_idx++;
            end else begin
                res.status = ST_EMPTY;
            end
            expected_words.push_back(res);
        end
    endfunction

    // send one word, returns at the edge where it is taken
    task automatic send_word(input t_in_word w);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_word  <= w;
        do @(posedge i_clk); while (o_in_stall);
        predict_word(w);
        words_sent++;
    endtask

    task automatic load_key(input logic [KEY_W-1:0] k, input logic is_last);
        t_in_word w;
        w.opcode = OP_LOAD;
        w.key    = k;
        w.last   = is_last;
        send_word(w);
    endtask

    // key and last carry junk on a read
    task automatic read_next();
        t_in_word w;
        w.opcode = OP_READ;
        w.key    = $urandom;
        w.last   = $urandom_range(0, 1);
        send_word(w);
    endtask

    // stop sending and wait for every pending result
    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (expected_words.size() != 0)
            @(posedge i_clk);
    endtask

    // register write once the block has gone quiet
    task automatic write_shift(input logic [SHIFT_W-1:0] value);
        drain();
        repeat (SETTLE) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we  <= 1'b0;
        shift_val = value;
    endtask

    // checking, receiver stall and run limit
    always @(posedge i_clk) begin
        t_out_word exp_w;
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("CHECK FAILED");
            $finish;
        end
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            results_checked++;
            if (expected_words.size() == 0) begin
                report($sformatf("unexpected result word %h", o_out_word));
            end else begin
                exp_w = expected_words.pop_front();
                if (o_out_word.sorted_key !== exp_w.sorted_key)
                    report($sformatf("sorted_key %h, want %h",
                                     o_out_word.sorted_key, exp_w.sorted_key));
                if (o_out_word.position !== exp_w.position)
                    report($sformatf("position %0d, want %0d",
                                     o_out_word.position, exp_w.position));
                if (o_out_word.last_of_run !== exp_w.last_of_run)
                    report($sformatf("last_of_run %b, want %b",
                                     o_out_word.last_of_run, exp_w.last_of_run));
                if (o_out_word.status !== exp_w.status)
                    report($sformatf("status %b, want %b",
                                     o_out_word.status, exp_w.status));
            end
            stall_left = draw_gap();
        end else if (stall_left > 0) begin
            stall_left--;
        end
        i_out_stall <= (stall_left > 0);
    end

    // reads straight after reset see nothing sorted
    task automatic test_reset_reads();
        read_next();
        read_next();
        drain();
    endtask

    // one key set, then a read past the end
    task automatic test_single_key();
        write_shift(5'd0);
        load_key(32'hFFFF_FFFF, 1'b1);
        read_next();
        read_next();
        drain();
    endtask

    // equal digits keep arrival order; a load mid-read opens a new set
    task automatic test_stable_order();
        load_key(32'hFFFF_FF00, 1'b0);
        load_key(32'h0000_0001, 1'b0);
        read_next();
        load_key(32'h8000_0000, 1'b0);
        load_key(32'h1234_5601, 1'b0);
        load_key(32'h0000_0000, 1'b1);
        read_next();
        read_next();
        read_next();
        load_key(32'hABCD_EF01, 1'b1);
        read_next();
        read_next();
        drain();
    endtask

    // digit at the top of the key, upper bits count as zero
    task automatic test_wide_shift();
        write_shift(5'd31);
        load_key(32'h8000_0000, 1'b0);
        load_key(32'h7FFF_FFFF, 1'b1);
        read_next();
        read_next();
        read_next();
        drain();
    endtask

    // fill the store, drop one more load whose last flag still runs the pass
    task automatic test_store_full();
        write_shift(5'd2);
        no_idle = 1'b1;
        for (int i = 0; i < MAX_KEYS; i++)
            load_key($urandom, 1'b0);
        load_key($urandom, 1'b1);
        for (int i = 0; i <= MAX_KEYS; i++)
            read_next();
        no_idle = 1'b0;
        drain();
    endtask

    // random sets of random size, reads that stop early or run past the end
    task automatic test_random_sets(input int budget);
        int               sent;
        int               set_no;
        int               set_size;
        int               reads;
        int               pick;
        bit               narrow;
        logic [KEY_W-1:0] k;
        logic [KEY_W-1:0] dmask;
        logic [SHIFT_W-1:0] new_shift;
        sent = 0;
        set_no = 0;
        while (sent < budget) begin
            set_no++;
            if (set_no % 6 == 0) begin
                pick = $urandom_range(0, 3);
                new_shift = (pick == 0) ? 5'd0 : (pick == 1) ? 5'd31 : 5'($urandom);
                write_shift(new_shift);
            end
            no_idle = ($urandom_range(0, 4) == 0);
            pick = $urandom_range(0, 99);
            if (pick < 80)
                set_size = $urandom_range(1, 24);
            else if (pick < 96)
                set_size = $urandom_range(25, 200);
            else
                set_size = $urandom_range(201, 700);
            // narrow sets crowd the keys into a few bins
            narrow = $urandom_range(0, 1);
            dmask = {{(KEY_W-DIGIT_BITS){1'b0}}, {DIGIT_BITS{1'b1}}} << shift_val;
            for (int i = 0; i < set_size; i++) begin
                if ($urandom_range(0, 9) == 0) begin
                    read_next();
                    sent++;
                end
                k = $urandom;
                if (narrow)
                    k = (k & ~dmask) | ((KEY_W'($urandom_range(0, 3)) << shift_val) & dmask);
                pick = $urandom_range(0, 19);
                if (pick == 0)
                    k = '0;
                else if (pick == 1)
                    k = '1;
                load_key(k, i == set_size - 1);
                sent++;
            end
            if ($urandom_range(0, 4) == 0)
                reads = $urandom_range(0, set_size);
            else
                reads = set_size + $urandom_range(0, 2);
            for (int i = 0; i < reads; i++)
                read_next();
            sent += reads;
        end
        no_idle = 1'b0;
        drain();
    endtask

    initial begin
        error_count = 0;
        words_sent = 0;
        results_checked = 0;
        passes_run = 0;
        cycle_count = 0;
        stall_left = 0;
        no_idle = 1'b0;
        foreach (bin_count[b]) bin_count[b] = 0;
        key_total = 0;
        read_idx = 0;
        sorted_ready = 1'b0;
        shift_val = '0;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_reads();
        test_single_key();
        test_stable_order();
        test_wide_shift();
        test_store_full();
        test_random_sets(RANDOM_WORDS);

        drain();
        repeat (SETTLE) @(posedge i_clk);
        if (expected_words.size() != 0)
            report($sformatf("%0d result words never arrived", expected_words.size()));

        $display("run covered %0d input words, %0d result words, %0d sort passes",
                 words_sent, results_checked, passes_run);
        $display("digit shifts 0, 2, 31 and random ones, store full and reads past the end");
        if (error_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("%0d mismatches", error_count);
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// File: filelist.f
src/rdsp_pkg.sv
src/rdsp_key_ram.sv
src/rdsp_hist_ram.sv
src/radix_digit_scatter_pass_top.sv
bench/tb_radix_digit_scatter_pass_top.sv
